@@ src/stpa_pkg.sv @@
// Package for the segment tree point-add / range-sum core.
// Holds the sequencer state type, command codes and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package stpa_pkg;

  // Fixed field widths of the transaction ports.
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned DELTA_W = 32;
  localparam int unsigned LEAF_W  = 10;

  // Command codes carried on in_cmd.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_U_RD,
    S_U_WR,
    S_Q_TEST,
    S_Q_ADDA,
    S_Q_CHKB,
    S_Q_ADDB
  } state_t;

endpackage

@@ src/segment_tree_point_add_range_sum_core.sv @@
// Segment tree core: point add and inclusive range sum over LEAVES leaves.
// An update reads and then writes each node from the leaf up to the root; a query
// walks both range bounds up the tree, adding the nodes that lie at their edges.
// One transaction at a time: the node RAM read port and the shared 64-bit adder set it.
// After reset a clearing pass zeroes the node RAM with busy high.
// Each result is strobed for one cycle on out_valid; the receiver cannot stall.
`timescale 1ns / 1ps

module segment_tree_point_add_range_sum_core #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_cmd,
  input  logic [stpa_pkg::LEAF_W-1:0]           in_leaf_index,
  input  logic signed [stpa_pkg::DELTA_W-1:0]   in_delta,
  input  logic [stpa_pkg::LEAF_W-1:0]           in_range_low,
  input  logic [stpa_pkg::LEAF_W-1:0]           in_range_high,
  output logic                                  out_valid,
  output logic signed [stpa_pkg::SUM_W-1:0]     out_range_sum
);

  localparam int unsigned DEPTH = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IW    = AW + 1;

  stpa_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]                 clr_r, clr_nxt;
  logic [AW-1:0]                 p_r, p_nxt;
  logic [IW-1:0]                 a_r, a_nxt;
  logic [IW-1:0]                 b_r, b_nxt;
  logic [stpa_pkg::SUM_W-1:0]    acc_r, acc_nxt;
  logic signed [stpa_pkg::DELTA_W-1:0] amt_r, amt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [stpa_pkg::SUM_W-1:0]    out_sum_r, out_sum_nxt;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [stpa_pkg::SUM_W-1:0]    ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [stpa_pkg::SUM_W-1:0]    ram_rdata;

  logic [stpa_pkg::SUM_W-1:0]    add_opnd;
  logic [stpa_pkg::SUM_W-1:0]    add_sum;

  logic [31:0]                   leaves32;
  logic [31:0]                   leaf32;
  logic [31:0]                   lo32;
  logic [31:0]                   hi_raw32;
  logic [31:0]                   hi32;
  logic [31:0]                   a32;
  logic [31:0]                   b32;
  logic [31:0]                   p32;
  logic                          leaf_ok;
  logic                          span_empty;
  logic                          accept;

  // Node sum storage.
  stpa_ram #(
    .WIDTH (stpa_pkg::SUM_W),
    .DEPTH (DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Transaction setup: leaf range check, range saturation and tree bounds.
  assign leaves32   = 32'(LEAVES);
  assign leaf32     = {{(32 - stpa_pkg::LEAF_W){1'b0}}, in_leaf_index};
  assign lo32       = {{(32 - stpa_pkg::LEAF_W){1'b0}}, in_range_low};
  assign hi_raw32   = {{(32 - stpa_pkg::LEAF_W){1'b0}}, in_range_high};
  assign hi32       = (hi_raw32 >= leaves32) ? (leaves32 - 32'd1) : hi_raw32;
  assign span_empty = (lo32 > hi32);
  assign a32        = leaves32 + lo32;
  assign b32        = leaves32 + hi32 + 32'd1;
  assign p32        = leaves32 + leaf32;
  assign leaf_ok    = (leaf32 < leaves32);

  assign accept = start && (state_r == stpa_pkg::S_IDLE);

  // Shared adder: node plus delta on update, accumulator plus node on query.
  assign add_opnd = (state_r == stpa_pkg::S_U_WR)
                    ? {{(stpa_pkg::SUM_W - stpa_pkg::DELTA_W){amt_r[stpa_pkg::DELTA_W-1]}},
                       amt_r}
                    : acc_r;
  assign add_sum  = ram_rdata + add_opnd;

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stpa_pkg::S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    acc_r     <= acc_nxt;
    amt_r     <= amt_nxt;
    out_sum_r <= out_sum_nxt;
  end

  // Sequencer: clearing pass, update walk up the tree, query walk of both bounds.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    p_nxt         = p_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    amt_nxt       = amt_r;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    ram_we        = 1'b0;
    ram_waddr     = p_r;
    ram_wdata     = add_sum;
    ram_raddr     = p_r;

    case (state_r)
      stpa_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = stpa_pkg::S_IDLE;
        end
      end
      stpa_pkg::S_IDLE: begin
        if (accept) begin
          amt_nxt = in_delta;
          p_nxt   = p32[AW-1:0];
          acc_nxt = '0;
          if (span_empty) begin
            a_nxt = '0;
            b_nxt = '0;
          end else begin
            a_nxt = a32[IW-1:0];
            b_nxt = b32[IW-1:0];
          end
          if (in_cmd == stpa_pkg::CMD_QUERY) begin
            state_nxt = stpa_pkg::S_Q_TEST;
          end else if (leaf_ok) begin
            state_nxt = stpa_pkg::S_U_RD;
          end
        end
      end
      stpa_pkg::S_U_RD: begin
        ram_raddr = p_r;
        state_nxt = stpa_pkg::S_U_WR;
      end
      stpa_pkg::S_U_WR: begin
        ram_we    = 1'b1;
        ram_waddr = p_r;
        ram_wdata = add_sum;
        p_nxt     = p_r >> 1;
        if (p_r == AW'(1)) begin
          state_nxt = stpa_pkg::S_IDLE;
        end else begin
          state_nxt = stpa_pkg::S_U_RD;
        end
      end
      stpa_pkg::S_Q_TEST: begin
        if (a_r >= b_r) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
          state_nxt     = stpa_pkg::S_IDLE;
        end else if (a_r[0]) begin
          ram_raddr = a_r[AW-1:0];
          state_nxt = stpa_pkg::S_Q_ADDA;
        end else begin
          state_nxt = stpa_pkg::S_Q_CHKB;
        end
      end
      stpa_pkg::S_Q_ADDA: begin
        acc_nxt   = add_sum;
        a_nxt     = a_r + 1'b1;
        state_nxt = stpa_pkg::S_Q_CHKB;
      end
      stpa_pkg::S_Q_CHKB: begin
        if (b_r[0]) begin
          b_nxt     = b_r - 1'b1;
          ram_raddr = b_nxt[AW-1:0];
          state_nxt = stpa_pkg::S_Q_ADDB;
        end else begin
          a_nxt     = a_r >> 1;
          b_nxt     = b_r >> 1;
          state_nxt = stpa_pkg::S_Q_TEST;
        end
      end
      stpa_pkg::S_Q_ADDB: begin
        acc_nxt   = add_sum;
        a_nxt     = a_r >> 1;
        b_nxt     = b_r >> 1;
        state_nxt = stpa_pkg::S_Q_TEST;
      end
      default: begin
        state_nxt = stpa_pkg::S_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != stpa_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

  // A query or an in-range update makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ((in_cmd == stpa_pkg::CMD_QUERY) || leaf_ok)) |=> busy)
    else $error("block not busy after an accepted transaction");

  // A result strobe lasts one cycle and the block is idle while it shows.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result strobed while a transaction is still in progress");

  // The query bounds never cross while the walk runs.
  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stpa_pkg::S_Q_TEST) |-> (a_r <= b_r))
    else $error("query bounds crossed");

  // While the clearing pass runs, the RAM is written with zeros and no result shows.
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stpa_pkg::S_CLEAR) |-> (ram_we && (ram_wdata == '0) && !out_valid_r))
    else $error("nonzero write or result during clearing pass");

endmodule

@@ src/stpa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the tree node sums; no dependencies.
`timescale 1ns / 1ps

module stpa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sim/tb_segment_tree_point_add_range_sum_core.sv @@
// Self-checking testbench for the segment tree point-add / range-sum core.
// Drives adds and queries; predicts range sums with a shadow tree or typed rows.
// Depends on stpa_pkg and segment_tree_point_add_range_sum_core.
`timescale 1ns / 1ps

module tb_segment_tree_point_add_range_sum_core;

  localparam int unsigned TREE_LEAVES = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Extra wait in each drain after the last owed sum has come.
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned RANDOM_OPS = 800;
  localparam int unsigned MAX_PRINTED = 40;

  // One row of stimulus; typed_sum is used where has_typed is set.
  typedef struct {
    logic                                cmd;
    logic [stpa_pkg::LEAF_W-1:0]         leaf;
    logic signed [stpa_pkg::DELTA_W-1:0] delta;
    logic [stpa_pkg::LEAF_W-1:0]         lo;
    logic [stpa_pkg::LEAF_W-1:0]         hi;
    bit                                  has_typed;
    logic signed [stpa_pkg::SUM_W-1:0]   typed_sum;
  } tree_op_t;

  logic                                clk;
  logic                                rst_n;
  logic                                start;
  logic                                busy;
  logic                                in_cmd;
  logic [stpa_pkg::LEAF_W-1:0]         in_leaf_index;
  logic signed [stpa_pkg::DELTA_W-1:0] in_delta;
  logic [stpa_pkg::LEAF_W-1:0]         in_range_low;
  logic [stpa_pkg::LEAF_W-1:0]         in_range_high;
  logic                                out_valid;
  logic signed [stpa_pkg::SUM_W-1:0]   out_range_sum;

  // Shadow copy of the node sums and the range sums still owed by the block.
  logic [stpa_pkg::SUM_W-1:0]        shadow_tree [2*TREE_LEAVES];
  logic signed [stpa_pkg::SUM_W-1:0] pending_sums [$];
  tree_op_t                          directed_ops [$];
  logic [stpa_pkg::LEAF_W-1:0]       hot_leaves [8];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned adds_sent;
  int unsigned queries_sent;
  int unsigned sums_checked;

  segment_tree_point_add_range_sum_core #(
    .LEAVES(TREE_LEAVES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_leaf_index(in_leaf_index),
    .in_delta(in_delta),
    .in_range_low(in_range_low),
    .in_range_high(in_range_high),
    .out_valid(out_valid),
    .out_range_sum(out_range_sum)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Add a sign-extended delta to a leaf and every ancestor.
  function automatic void shadow_add(int unsigned leaf,
                                     logic signed [stpa_pkg::DELTA_W-1:0] delta);
    int unsigned node;
    logic [stpa_pkg::SUM_W-1:0] amount;
    if (leaf >= TREE_LEAVES) return;
    amount = {{(stpa_pkg::SUM_W-stpa_pkg::DELTA_W){delta[stpa_pkg::DELTA_W-1]}}, delta};
    node = TREE_LEAVES + leaf;
    while (node >= 1) begin
      shadow_tree[node] = shadow_tree[node] + amount;
      node = node >> 1;
    end
  endfunction

  // Bottom-up inclusive range sum over the shadow tree.
  function automatic logic [stpa_pkg::SUM_W-1:0] shadow_range_sum(int unsigned lo,
                                                                 int unsigned hi);
    logic [stpa_pkg::SUM_W-1:0] acc;
    int unsigned a;
    int unsigned b;
    acc = '0;
    if (hi >= TREE_LEAVES) hi = TREE_LEAVES - 1;
    if (lo > hi) return '0;
    a = TREE_LEAVES + lo;
    b = TREE_LEAVES + hi + 1;
    while (a < b) begin
      if (a & 1) begin
        acc = acc + shadow_tree[a];
        a = a + 1;
      end
      if (b & 1) begin
        b = b - 1;
        acc = acc + shadow_tree[b];
      end
      a = a >> 1;
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic void push_row(logic cmd, int unsigned leaf,
                                   logic [stpa_pkg::DELTA_W-1:0] delta,
                                   int unsigned lo, int unsigned hi, bit has_typed,
                                   logic [stpa_pkg::SUM_W-1:0] typed_sum);
    tree_op_t row;
    row.cmd       = cmd;
    row.leaf      = leaf[stpa_pkg::LEAF_W-1:0];
    row.delta     = delta;
    row.lo        = lo[stpa_pkg::LEAF_W-1:0];
    row.hi        = hi[stpa_pkg::LEAF_W-1:0];
    row.has_typed = has_typed;
    row.typed_sum = typed_sum;
    directed_ops.push_back(row);
  endfunction

  task automatic report_mismatch(string what, logic [stpa_pkg::SUM_W-1:0] got,
                                 logic [stpa_pkg::SUM_W-1:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("ERROR cycle %0d: %s got %h, expected %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Present a transaction, hold it until busy is low, then update the prediction.
  task automatic send_op(tree_op_t op, bit allow_gap);
    if (allow_gap && $urandom_range(99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(40, 1)) @(posedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= op.cmd;
    in_leaf_index <= op.leaf;
    in_delta      <= op.delta;
    in_range_low  <= op.lo;
    in_range_high <= op.hi;
    do @(posedge clk); while (busy);
    if (op.cmd == stpa_pkg::CMD_ADD) begin
      shadow_add(op.leaf, op.delta);
      adds_sent++;
    end else begin
      if (op.has_typed) pending_sums.push_back(op.typed_sum);
      else pending_sums.push_back(shadow_range_sum(op.lo, op.hi));
      queries_sent++;
    end
  endtask

  // Stop sending until every owed sum has come and the block has gone quiet.
  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Build one random transaction; 35% of leaf picks hit one of eight hot leaves.
  function automatic tree_op_t random_op();
    tree_op_t op;
    int unsigned pick;
    int unsigned a;
    int unsigned b;
    op.has_typed = 1'b0;
    op.typed_sum = '0;
    op.cmd       = ($urandom_range(99) < 50) ? stpa_pkg::CMD_ADD : stpa_pkg::CMD_QUERY;
    op.leaf      = ($urandom_range(99) < 35) ? hot_leaves[$urandom_range(7)]
                                              : stpa_pkg::LEAF_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) op.delta = ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    else if (pick < 50) op.delta = stpa_pkg::DELTA_W'($signed($urandom_range(200)) - 100);
    else op.delta = $urandom;
    a = $urandom_range(TREE_LEAVES - 1);
    b = $urandom_range(TREE_LEAVES - 1);
    pick = $urandom_range(99);
    if (pick < 10) begin
      // Reversed range: low above high.
      if (a == b) b = (a + 1) % TREE_LEAVES;
      op.lo = stpa_pkg::LEAF_W'((a > b) ? a : b);
      op.hi = stpa_pkg::LEAF_W'((a > b) ? b : a);
    end else if (pick < 20) begin
      op.lo = stpa_pkg::LEAF_W'(a);
      op.hi = stpa_pkg::LEAF_W'(a);
    end else if (pick < 25) begin
      op.lo = '0;
      op.hi = stpa_pkg::LEAF_W'(TREE_LEAVES - 1);
    end else begin
      op.lo = stpa_pkg::LEAF_W'((a < b) ? a : b);
      op.hi = stpa_pkg::LEAF_W'((a < b) ? b : a);
    end
    return op;
  endfunction

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d sums owed", cycle_count, pending_sums.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Compare each strobed range sum with the oldest owed sum.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_sums.size() == 0) begin
        report_mismatch("unexpected range_sum", out_range_sum, '0);
      end else begin
        if (out_range_sum !== pending_sums[0])
          report_mismatch("range_sum", out_range_sum, pending_sums[0]);
        void'(pending_sums.pop_front());
        sums_checked++;
      end
    end
  end

  initial begin
    tree_op_t op;
    bit gaps_on;
    cycle_count    = 0;
    mismatch_count = 0;
    adds_sent      = 0;
    queries_sent   = 0;
    sums_checked   = 0;
    foreach (shadow_tree[i]) shadow_tree[i] = '0;
    foreach (hot_leaves[i]) hot_leaves[i] = stpa_pkg::LEAF_W'($urandom);
    hot_leaves[0] = '0;
    hot_leaves[1] = '1;

    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_cmd        <= stpa_pkg::CMD_ADD;
    in_leaf_index <= '0;
    in_delta      <= '0;
    in_range_low  <= '0;
    in_range_high <= '0;

    // Directed rows: cleared tree, extreme deltas and leaves, reversed ranges.
    push_row(stpa_pkg::CMD_QUERY, 0, 0, 0, 1023, 1, 64'd0);
    push_row(stpa_pkg::CMD_QUERY, 0, 0, 5, 3, 1, 64'd0);
    push_row(stpa_pkg::CMD_ADD, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
    push_row(stpa_pkg::CMD_ADD, 1023, 32'h8000_0000, 0, 0, 0, 0);
    push_row(stpa_pkg::CMD_QUERY, 0, 0, 0, 0, 1, 64'h0000_0000_7FFF_FFFF);
    push_row(stpa_pkg::CMD_QUERY, 0, 0, 1023, 1023, 1, 64'hFFFF_FFFF_8000_0000);
    push_row(stpa_pkg::CMD_QUERY, 0, 0, 0, 1023, 1, 64'hFFFF_FFFF_FFFF_FFFF);
    push_row(stpa_pkg::CMD_ADD, 512, 32'hFFFF_FFFF, 0, 0, 0, 0);
    push_row(stpa_pkg::CMD_ADD, 511, 32'h0000_0001, 0, 0, 0, 0);
    push_row(stpa_pkg::CMD_QUERY, 0, 0, 511, 512, 1, 64'd0);
    push_row(stpa_pkg::CMD_QUERY, 0, 0, 1023, 0, 1, 64'd0);
    push_row(stpa_pkg::CMD_ADD, 341, 32'h5555_5555, 0, 0, 0, 0);
    push_row(stpa_pkg::CMD_ADD, 682, 32'hAAAA_AAAA, 0, 0, 0, 0);
    push_row(stpa_pkg::CMD_QUERY, 0, 0, 341, 682, 0, 0);
    push_row(stpa_pkg::CMD_QUERY, 0, 0, 1, 1022, 0, 0);
    push_row(stpa_pkg::CMD_QUERY, 0, 0, 682, 341, 1, 64'd0);
    push_row(stpa_pkg::CMD_ADD, 1023, 32'h7FFF_FFFF, 0, 0, 0, 0);
    push_row(stpa_pkg::CMD_QUERY, 0, 0, 512, 1023, 0, 0);
    push_row(stpa_pkg::CMD_QUERY, 0, 0, 0, 1023, 0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[i]) send_op(directed_ops[i], 1'b1);

    // Random traffic, with a drain early on and a stretch without gaps.
    for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
      if (n == 200) wait_for_drain();
      gaps_on = !(n >= 350 && n < 500);
      op = random_op();
      send_op(op, gaps_on);
    end

    wait_for_drain();
    $display("Sent %0d adds and %0d queries; %0d range sums compared in %0d cycles.",
             adds_sent, queries_sent, sums_checked, cycle_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/stpa_pkg.sv
src/stpa_ram.sv
src/segment_tree_point_add_range_sum_core.sv
sim/tb_segment_tree_point_add_range_sum_core.sv
